[rtl/rsr_pkg.sv]
`timescale 1ns / 1ps

package rsr_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {OP_ADD, OP_ADVANCE, OP_REPORT, OP_NONE} op_t;

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] min;
        logic [31:0] max;
        logic [31:0] mean;
        logic [63:0] sq_sum;
        logic [63:0] dev_sum;
    } rec_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

endpackage

[rtl/running_stats_ring.sv]
`timescale 1ns / 1ps
// channel  dir  tdata                                              tuser        tlast
// s_*      in   [31:0] sample                                      [1:0] op     -
// m_*      out  slot_number,min,max,peak,mean,rms,std (200 bits)   [0] empty    last row
//
// Advance is taken in the idle state itself. Add waits on the shared 64-step divider.
// Report: each non-empty slot runs two 64-step divides and two 32-step roots; an empty
// slot skips them, and each row may also wait for m_tready.
// s_tready is high only while idle; a report row waits in the output register.
// Reset (rst_n, async) clears per-slot valid bits, so all slots read as empty.

module running_stats_ring
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] sample
    input  logic [1:0]   s_tuser,   // [1:0] op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // slot_number[5:0], out_min, out_max, peak_magnitude,
                                    // out_mean, rms_value[30:0], std_deviation[30:0], pad
    output logic [0:0]   m_tuser,   // [0] empty_slot
    output logic         m_tlast
);

    localparam int SW = rsr_pkg::SLOT_W;
    localparam int FW = rsr_pkg::FILL_W;

    typedef enum logic [4:0] {
        S_IDLE, S_ADD_LOAD, S_ADD_SQ, S_ADD_DIV, S_ADD_MUL, S_ADD_ACC,
        S_REP_RD, S_REP_LOAD, S_REP_D1S, S_REP_D1W, S_REP_Q1S, S_REP_Q1W,
        S_REP_D2S, S_REP_D2W, S_REP_Q2S, S_REP_Q2W, S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [SW-1:0]       cur_reg, cur_next;
    logic [FW-1:0]       filled_reg, filled_next;
    logic [FW-1:0]       idx_reg, idx_next;
    logic [rsr_pkg::SLOTS-1:0] valid_reg, valid_next;
    rsr_pkg::rec_t       rec_reg, rec_next;
    logic [31:0]         samp_reg, samp_next;
    logic                neg_reg, neg_next;
    logic [32:0]         dmag_reg, dmag_next;
    logic [65:0]         prod_reg, prod_next;
    logic [30:0]         rms_reg, rms_next;
    logic [30:0]         std_reg, std_next;
    logic                mval_reg, mval_next;
    logic [199:0]        mdata_reg, mdata_next;
    logic                mempty_reg, mempty_next;
    logic                mlast_reg, mlast_next;

    rsr_pkg::rec_t       mem [rsr_pkg::SLOTS];
    rsr_pkg::rec_t       rdata_reg;
    logic                rvalid_reg;
    logic [SW-1:0]       rd_addr;
    logic                wr_en;

    rsr_pkg::div_req_t   div_req;
    rsr_pkg::div_rsp_t   div_rsp;
    rsr_pkg::sqrt_req_t  sq_req;
    rsr_pkg::sqrt_rsp_t  sq_rsp;

    rsr_pkg::rec_t       ld;
    logic                accept;
    logic [32:0]         d1;
    logic [32:0]         e;
    logic [32:0]         mul_a, mul_b;
    logic [65:0]         mul_p;
    logic [32:0]         q;
    logic signed [33:0]  qs;
    logic signed [33:0]  msum;
    logic signed [33:0]  negmin;
    logic signed [33:0]  maxs;
    logic [31:0]         peak;
    logic [63:0]         psat;
    logic                out_free;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [30:0] sat31(input logic [31:0] r);
        return r[31] ? 31'h7FFF_FFFF : r[30:0];
    endfunction

    rsr_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
    rsr_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sq_req), .rsp(sq_rsp));

    assign rd_addr = (state_reg == S_IDLE) ? cur_reg : idx_reg[SW-1:0];
    assign wr_en   = (state_reg == S_ADD_ACC);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cur_reg] <= rec_next;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= valid_reg[rd_addr];
        end
    end

    assign ld       = rvalid_reg ? rdata_reg : '0;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mval_reg || m_tready;

    assign d1     = {ld.mean[31], ld.mean} ^ '0;
    assign e      = {samp_reg[31], samp_reg} - {rec_reg.mean[31], rec_reg.mean};
    assign q      = div_rsp.quotient[32:0];
    assign qs     = neg_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    assign msum   = $signed({{2{rec_reg.mean[31]}}, rec_reg.mean}) + qs;
    assign negmin = -$signed({{2{rec_reg.min[31]}}, rec_reg.min});
    assign maxs   = $signed({{2{rec_reg.max[31]}}, rec_reg.max});
    assign peak   = (maxs > negmin) ? maxs[31:0] : negmin[31:0];
    assign psat   = (prod_reg[65:64] != 2'b00) ? '1 : prod_reg[63:0];
    assign mul_p  = {33'd0, mul_a} * {33'd0, mul_b};

    always_comb
    begin
        mul_a = {1'b0, samp_reg[31] ? -samp_reg : samp_reg};
        mul_b = mul_a;
        if (state_reg == S_ADD_MUL)
        begin
            mul_a = dmag_reg;
            mul_b = e[32] ? -e : e;
        end
    end

    always_comb
    begin
        logic [32:0] dd;
        logic        empty;

        state_next  = state_reg;
        cur_next    = cur_reg;
        filled_next = filled_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        rec_next    = rec_reg;
        samp_next   = samp_reg;
        neg_next    = neg_reg;
        dmag_next   = dmag_reg;
        prod_next   = prod_reg;
        rms_next    = rms_reg;
        std_next    = std_reg;
        mval_next   = m_tready ? 1'b0 : mval_reg;
        mdata_next  = mdata_reg;
        mempty_next = mempty_reg;
        mlast_next  = mlast_reg;
        div_req     = '0;
        sq_req      = '0;
        dd          = {samp_reg[31], samp_reg} - d1;
        empty       = (rec_reg.count == 32'd0);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    samp_next = s_tdata;
                    case (rsr_pkg::op_t'(s_tuser))
                        rsr_pkg::OP_ADD: state_next = S_ADD_LOAD;
                        rsr_pkg::OP_ADVANCE:
                        begin
                            cur_next = (cur_reg == SW'(rsr_pkg::SLOTS - 1)) ? '0
                                                                          : cur_reg + SW'(1);
                            valid_next[cur_next] = 1'b0;
                            if (filled_reg != FW'(rsr_pkg::SLOTS))
                            begin
                                filled_next = filled_reg + FW'(1);
                            end
                        end
                        rsr_pkg::OP_REPORT:
                        begin
                            if (filled_reg != '0)
                            begin
                                idx_next   = '0;
                                state_next = S_REP_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ADD_LOAD:
            begin
                rec_next = ld;
                if ((ld.count == 32'd0) || ($signed(ld.max) < $signed(samp_reg)))
                begin
                    rec_next.max = samp_reg;
                end
                if ((ld.count == 32'd0) || ($signed(ld.min) > $signed(samp_reg)))
                begin
                    rec_next.min = samp_reg;
                end
                if (ld.count != '1)
                begin
                    rec_next.count = ld.count + 32'd1;
                end
                neg_next   = dd[32];
                dmag_next  = dd[32] ? -dd : dd;
                prod_next  = mul_p;
                state_next = S_ADD_SQ;
            end
            S_ADD_SQ:
            begin
                rec_next.sq_sum  = sat_add(rec_reg.sq_sum, prod_reg[63:0]);
                div_req.start    = 1'b1;
                div_req.dividend = {31'd0, dmag_reg};
                div_req.divisor  = rec_reg.count;
                state_next       = S_ADD_DIV;
            end
            S_ADD_DIV:
            begin
                if (div_rsp.done)
                begin
                    rec_next.mean = msum[31:0];
                    state_next    = S_ADD_MUL;
                end
            end
            S_ADD_MUL:
            begin
                prod_next  = mul_p;
                state_next = S_ADD_ACC;
            end
            S_ADD_ACC:
            begin
                rec_next.dev_sum    = sat_add(rec_reg.dev_sum, psat);
                valid_next[cur_reg] = 1'b1;
                state_next          = S_IDLE;
            end
            S_REP_RD: state_next = S_REP_LOAD;
            S_REP_LOAD:
            begin
                rec_next   = ld;
                rms_next   = '0;
                std_next   = '0;
                state_next = (ld.count == 32'd0) ? S_EMIT : S_REP_D1S;
            end
            S_REP_D1S:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = rec_reg.sq_sum;
                div_req.divisor  = rec_reg.count;
                state_next       = S_REP_D1W;
            end
            S_REP_D1W: if (div_rsp.done) state_next = S_REP_Q1S;
            S_REP_Q1S:
            begin
                sq_req.start    = 1'b1;
                sq_req.radicand = div_rsp.quotient;
                state_next      = S_REP_Q1W;
            end
            S_REP_Q1W:
            begin
                if (sq_rsp.done)
                begin
                    rms_next   = sat31(sq_rsp.root);
                    state_next = S_REP_D2S;
                end
            end
            S_REP_D2S:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = rec_reg.dev_sum;
                div_req.divisor  = rec_reg.count;
                state_next       = S_REP_D2W;
            end
            S_REP_D2W: if (div_rsp.done) state_next = S_REP_Q2S;
            S_REP_Q2S:
            begin
                sq_req.start    = 1'b1;
                sq_req.radicand = div_rsp.quotient;
                state_next      = S_REP_Q2W;
            end
            S_REP_Q2W:
            begin
                if (sq_rsp.done)
                begin
                    std_next   = sat31(sq_rsp.root);
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    mval_next   = 1'b1;
                    mempty_next = empty;
                    mlast_next  = ((idx_reg + FW'(1)) == filled_reg);
                    mdata_next  = {4'd0, std_reg, rms_reg, rec_reg.mean, peak,
                                   rec_reg.max, rec_reg.min, 6'(idx_reg)};
                    if ((idx_reg + FW'(1)) == filled_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + FW'(1);
                        state_next = S_REP_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cur_reg    <= '0;
            filled_reg <= '0;
            idx_reg    <= '0;
            valid_reg  <= '0;
            rec_reg    <= '0;
            samp_reg   <= '0;
            neg_reg    <= 1'b0;
            dmag_reg   <= '0;
            prod_reg   <= '0;
            rms_reg    <= '0;
            std_reg    <= '0;
            mval_reg   <= 1'b0;
            mdata_reg  <= '0;
            mempty_reg <= 1'b0;
            mlast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            filled_reg <= filled_next;
            idx_reg    <= idx_next;
            valid_reg  <= valid_next;
            rec_reg    <= rec_next;
            samp_reg   <= samp_next;
            neg_reg    <= neg_next;
            dmag_reg   <= dmag_next;
            prod_reg   <= prod_next;
            rms_reg    <= rms_next;
            std_reg    <= std_next;
            mval_reg   <= mval_next;
            mdata_reg  <= mdata_next;
            mempty_reg <= mempty_next;
            mlast_reg  <= mlast_next;
        end
    end

    assign m_tvalid   = mval_reg;
    assign m_tdata    = mdata_reg;
    assign m_tuser[0] = mempty_reg;
    assign m_tlast    = mlast_reg;

`ifndef SYNTHESIS
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!div_rsp.busy && !sq_rsp.busy))
        else $error("input taken while a shared unit is busy");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    a_filled: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= FW'(rsr_pkg::SLOTS))
        else $error("filled slot count beyond ring size");

    a_empty_row: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[195:6] == '0))
        else $error("empty slot row carries nonzero statistics");
`endif

endmodule

[rtl/rsr_div.sv]
`timescale 1ns / 1ps

module rsr_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  rsr_pkg::div_req_t  req,
    output rsr_pkg::div_rsp_t  rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [32:0] shifted;
    logic [32:0] diff;
    logic        take;

    assign shifted = {rem_reg, quo_reg[63]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign take    = !diff[32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd63;
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                quo_reg <= {quo_reg[62:0], take};
                rem_reg <= take ? diff[31:0] : shifted[31:0];
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/rsr_sqrt.sv]
`timescale 1ns / 1ps

module rsr_sqrt
(
    input  logic                clk,
    input  logic                rst_n,
    input  rsr_pkg::sqrt_req_t  req,
    output rsr_pkg::sqrt_rsp_t  rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;
    logic        ge;

    assign trial = res_reg + bit_reg;
    assign ge    = (x_reg >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            x_reg    <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                x_reg    <= req.radicand;
                res_reg  <= '0;
                bit_reg  <= 64'h4000_0000_0000_0000;
            end
            else if (busy_reg)
            begin
                if (ge)
                begin
                    x_reg   <= x_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0])
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.root = res_reg[31:0];

endmodule
